/* sv/ts_pkg.sv */
// ============================================================================
// ts_pkg: shared types, codes and helpers of the token scanner
// Scan modes, token kinds, character codes, the keyword table, the token
// record and the small decode functions used by the scan core.
// ============================================================================
package ts_pkg;

    // scan modes of the pending token
    localparam logic [3:0] M_IDLE     = 4'd0;
    localparam logic [3:0] M_IDENT    = 4'd1;
    localparam logic [3:0] M_NUMBER   = 4'd2;
    localparam logic [3:0] M_NUMDOT   = 4'd3;
    localparam logic [3:0] M_FRACTION = 4'd4;
    localparam logic [3:0] M_STRING   = 4'd5;
    localparam logic [3:0] M_COMMENT  = 4'd6;
    localparam logic [3:0] M_SLASH    = 4'd7;
    localparam logic [3:0] M_BANG     = 4'd8;
    localparam logic [3:0] M_EQUAL    = 4'd9;
    localparam logic [3:0] M_LESS     = 4'd10;
    localparam logic [3:0] M_GREATER  = 4'd11;

    // token kinds
    localparam logic [4:0] K_LPAREN     = 5'd0;
    localparam logic [4:0] K_RPAREN     = 5'd1;
    localparam logic [4:0] K_LBRACE     = 5'd2;
    localparam logic [4:0] K_RBRACE     = 5'd3;
    localparam logic [4:0] K_SEMI       = 5'd4;
    localparam logic [4:0] K_COMMA      = 5'd5;
    localparam logic [4:0] K_DOT        = 5'd6;
    localparam logic [4:0] K_MINUS      = 5'd7;
    localparam logic [4:0] K_PLUS       = 5'd8;
    localparam logic [4:0] K_SLASH      = 5'd9;
    localparam logic [4:0] K_STAR       = 5'd10;
    localparam logic [4:0] K_BANG       = 5'd11;
    localparam logic [4:0] K_BANG_EQ    = 5'd12;
    localparam logic [4:0] K_EQUAL      = 5'd13;
    localparam logic [4:0] K_EQ_EQ      = 5'd14;
    localparam logic [4:0] K_LESS       = 5'd15;
    localparam logic [4:0] K_LESS_EQ    = 5'd16;
    localparam logic [4:0] K_GREATER    = 5'd17;
    localparam logic [4:0] K_GREATER_EQ = 5'd18;
    localparam logic [4:0] K_IDENT      = 5'd19;
    localparam logic [4:0] K_STRING     = 5'd20;
    localparam logic [4:0] K_NUMBER     = 5'd21;
    localparam logic [4:0] K_KEYWORD0   = 5'd22;
    localparam logic [4:0] K_ERROR      = 5'd30;
    localparam logic [4:0] K_END        = 5'd31;

    // character codes
    localparam logic [7:0] CH_LPAREN  = "(";
    localparam logic [7:0] CH_RPAREN  = ")";
    localparam logic [7:0] CH_LBRACE  = "{";
    localparam logic [7:0] CH_RBRACE  = "}";
    localparam logic [7:0] CH_SEMI    = ";";
    localparam logic [7:0] CH_COMMA   = ",";
    localparam logic [7:0] CH_DOT     = ".";
    localparam logic [7:0] CH_MINUS   = "-";
    localparam logic [7:0] CH_PLUS    = "+";
    localparam logic [7:0] CH_STAR    = "*";
    localparam logic [7:0] CH_SLASH   = "/";
    localparam logic [7:0] CH_BANG    = "!";
    localparam logic [7:0] CH_EQUAL   = "=";
    localparam logic [7:0] CH_LESS    = "<";
    localparam logic [7:0] CH_GREATER = ">";
    localparam logic [7:0] CH_QUOTE   = "\"";
    localparam logic [7:0] CH_SPACE   = " ";
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;

    // token length saturates here
    localparam logic [15:0] LEN_MAX = 16'hFFFF;

    // keyword table, first character in the top byte
    localparam int KW_COUNT     = 8;
    localparam int KW_CMP_CHARS = 6;
    typedef logic [KW_CMP_CHARS*8-1:0] kw_text_t;
    localparam kw_text_t KW_TEXT [KW_COUNT] = '{
        {"let", 24'd0}, {"print", 8'd0}, {"true", 16'd0}, {"false", 8'd0},
        {"if", 32'd0}, {"else", 16'd0}, {"fun", 24'd0}, "return"
    };
    localparam logic [2:0] KW_LEN [KW_COUNT] = '{
        3'd3, 3'd5, 3'd4, 3'd5, 3'd2, 3'd4, 3'd3, 3'd6
    };

    // token queue sizing
    localparam int TQ_DEPTH = 8;
    localparam int TQ_AW    = 3;
    localparam int TQ_CW    = 4;
    localparam int TQ_BURST = 3;

    // one result transaction
    typedef struct packed {
        logic [4:0]  kind;
        logic [15:0] start;
        logic [15:0] length;
        logic        last;
    } ts_token_t;

    // tokens released when a pending token closes
    typedef struct packed {
        logic      v0;
        ts_token_t t0;
        logic      v1;
        ts_token_t t1;
    } ts_flush_t;

    // decode of a byte scanned with nothing pending
    typedef struct packed {
        logic       emit;
        logic [4:0] kind;
        logic [3:0] mode;
        logic       open;
        logic       word;
    } ts_fresh_t;

    function automatic logic is_alpha(logic [7:0] c);
        return c inside {["a":"z"], ["A":"Z"]};
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return c inside {["0":"9"]};
    endfunction

    function automatic logic is_space(logic [7:0] c);
        return c inside {CH_SPACE, [CH_TAB:CH_CR]};
    endfunction

    function automatic logic [15:0] len_inc(logic [15:0] len);
        return (len == LEN_MAX) ? len : len + 16'd1;
    endfunction

    // keyword match: exact length and exact bytes
    function automatic logic [4:0] kw_kind(kw_text_t text, logic [15:0] len);
        logic [4:0] kind;
        logic       same;
        kind = K_IDENT;
        for (int k = KW_COUNT - 1; k >= 0; k--)
        begin
            same = (len == 16'(KW_LEN[k]));
            for (int i = 0; i < KW_CMP_CHARS; i++)
            begin
                if ((i < int'(KW_LEN[k])) &&
                    (text[(KW_CMP_CHARS-1-i)*8 +: 8] != KW_TEXT[k][(KW_CMP_CHARS-1-i)*8 +: 8]))
                begin
                    same = 1'b0;
                end
            end
            if (same)
            begin
                kind = K_KEYWORD0 + 5'(k);
            end
        end
        return kind;
    endfunction

    // tokens of a pending token that is closed
    function automatic ts_flush_t flush_toks(logic [3:0] mode, logic [15:0] start,
                                             logic [15:0] len, logic [4:0] word_kind,
                                             logic [15:0] dot_start);
        ts_flush_t f;
        f = '0;
        f.v0 = 1'b1;
        f.t0.start = start;
        f.t0.length = 16'd1;
        case (mode)
            M_IDENT:
            begin
                f.t0.kind = word_kind;
                f.t0.length = len;
            end
            M_NUMBER, M_FRACTION:
            begin
                f.t0.kind = K_NUMBER;
                f.t0.length = len;
            end
            M_NUMDOT:
            begin
                f.t0.kind = K_NUMBER;
                f.t0.length = len;
                f.v1 = 1'b1;
                f.t1.kind = K_DOT;
                f.t1.start = dot_start;
                f.t1.length = 16'd1;
            end
            M_STRING:
            begin
                f.t0.kind = K_ERROR;
                f.t0.length = len;
            end
            M_SLASH:   f.t0.kind = K_SLASH;
            M_BANG:    f.t0.kind = K_BANG;
            M_EQUAL:   f.t0.kind = K_EQUAL;
            M_LESS:    f.t0.kind = K_LESS;
            M_GREATER: f.t0.kind = K_GREATER;
            default:   f.v0 = 1'b0;
        endcase
        return f;
    endfunction

    // byte scanned with nothing pending
    function automatic ts_fresh_t fresh_scan(logic [7:0] c);
        ts_fresh_t f;
        f = '0;
        f.mode = M_IDLE;
        f.kind = K_ERROR;
        if (is_space(c))
        begin
            f.emit = 1'b0;
        end
        else if (is_alpha(c))
        begin
            f.mode = M_IDENT;
            f.open = 1'b1;
            f.word = 1'b1;
        end
        else if (is_digit(c))
        begin
            f.mode = M_NUMBER;
            f.open = 1'b1;
        end
        else
        begin
            f.emit = 1'b1;
            case (c)
                CH_LPAREN: f.kind = K_LPAREN;
                CH_RPAREN: f.kind = K_RPAREN;
                CH_LBRACE: f.kind = K_LBRACE;
                CH_RBRACE: f.kind = K_RBRACE;
                CH_SEMI:   f.kind = K_SEMI;
                CH_COMMA:  f.kind = K_COMMA;
                CH_DOT:    f.kind = K_DOT;
                CH_MINUS:  f.kind = K_MINUS;
                CH_PLUS:   f.kind = K_PLUS;
                CH_STAR:   f.kind = K_STAR;
                CH_SLASH:
                begin
                    f.emit = 1'b0;
                    f.open = 1'b1;
                    f.mode = M_SLASH;
                end
                CH_BANG:
                begin
                    f.emit = 1'b0;
                    f.open = 1'b1;
                    f.mode = M_BANG;
                end
                CH_EQUAL:
                begin
                    f.emit = 1'b0;
                    f.open = 1'b1;
                    f.mode = M_EQUAL;
                end
                CH_LESS:
                begin
                    f.emit = 1'b0;
                    f.open = 1'b1;
                    f.mode = M_LESS;
                end
                CH_GREATER:
                begin
                    f.emit = 1'b0;
                    f.open = 1'b1;
                    f.mode = M_GREATER;
                end
                CH_QUOTE:
                begin
                    f.emit = 1'b0;
                    f.open = 1'b1;
                    f.mode = M_STRING;
                end
                default:   f.kind = K_ERROR;
            endcase
        end
        return f;
    endfunction

endpackage

/* sv/ts_scan_core.sv */
// ============================================================================
// ts_scan_core: per-byte scan logic and scanner state
// Takes one registered byte per cycle while item_valid is high, updates the pending
// token and produces up to three tokens for the token queue in the same cycle.
// ============================================================================
module ts_scan_core #(
    parameter int POSITION_BITS = 16,
    parameter int KEYWORD_CHARS = 6
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    input  logic [7:0]           char_code,
    input  logic                 end_of_source,
    output logic [1:0]           push_cnt,
    output ts_pkg::ts_token_t    push_tok [ts_pkg::TQ_BURST]
);

    localparam int WCW = $clog2(KEYWORD_CHARS + 1);
    localparam int WIW = $clog2(KEYWORD_CHARS);
    localparam logic [POSITION_BITS-1:0] POS_ONE = {{(POSITION_BITS-1){1'b0}}, 1'b1};
    localparam logic [WCW-1:0] WC_ONE = {{(WCW-1){1'b0}}, 1'b1};
    localparam logic [WCW-1:0] WC_FULL = WCW'(KEYWORD_CHARS);

    // scanner state
    logic [3:0]               mode_reg;
    logic [POSITION_BITS-1:0] pos_reg;
    logic [POSITION_BITS-1:0] start_reg;
    logic [15:0]              len_reg;
    logic [WCW-1:0]           wcnt_reg;
    logic [7:0]               pfx_reg [KEYWORD_CHARS];

    // state after the byte itself, before end of source
    logic [3:0]               mode_next;
    logic [POSITION_BITS-1:0] start_next;
    logic [15:0]              len_next;
    logic [WCW-1:0]           wcnt_next;
    logic [7:0]               pfx_next [KEYWORD_CHARS];

    logic [POSITION_BITS-1:0] pos_inc;
    logic [POSITION_BITS-1:0] pos_dec;
    logic [15:0]              pos16;
    ts_pkg::kw_text_t         text_cur;
    ts_pkg::kw_text_t         text_new;
    ts_pkg::ts_flush_t        flush_cur;
    ts_pkg::ts_flush_t        flush_end;
    ts_pkg::ts_fresh_t        fresh;
    logic                     do_flush;
    logic                     do_fresh;
    logic                     direct_v;
    ts_pkg::ts_token_t        direct_tok;
    ts_pkg::ts_token_t        tk [4];
    logic [2:0]               tok_n;

    assign pos_inc = pos_reg + POS_ONE;
    assign pos_dec = pos_reg - POS_ONE;
    assign pos16   = 16'(pos_reg);
    assign fresh   = ts_pkg::fresh_scan(char_code);

    // keyword prefix text, before and after this byte
    always_comb
    begin
        text_cur = '0;
        text_new = '0;
        for (int i = 0; i < ts_pkg::KW_CMP_CHARS; i++)
        begin
            text_cur[(ts_pkg::KW_CMP_CHARS-1-i)*8 +: 8] = pfx_reg[i];
            text_new[(ts_pkg::KW_CMP_CHARS-1-i)*8 +: 8] = pfx_next[i];
        end
    end

    // closing tokens of the old pending token and of the one left at end
    assign flush_cur = ts_pkg::flush_toks(mode_reg, 16'(start_reg), len_reg,
                                          ts_pkg::kw_kind(text_cur, len_reg),
                                          16'(pos_dec));
    assign flush_end = ts_pkg::flush_toks(mode_next, 16'(start_next), len_next,
                                          ts_pkg::kw_kind(text_new, len_next), pos16);

    // byte step of the scan mode
    always_comb
    begin
        mode_next  = mode_reg;
        start_next = start_reg;
        len_next   = len_reg;
        wcnt_next  = wcnt_reg;
        pfx_next   = pfx_reg;
        do_flush   = 1'b0;
        do_fresh   = 1'b0;
        direct_v   = 1'b0;
        direct_tok = '0;
        case (mode_reg)
            ts_pkg::M_IDENT:
            begin
                if (ts_pkg::is_alpha(char_code) || ts_pkg::is_digit(char_code))
                begin
                    if (wcnt_reg < WC_FULL)
                    begin
                        pfx_next[wcnt_reg[WIW-1:0]] = char_code;
                        wcnt_next = wcnt_reg + WC_ONE;
                    end
                    len_next = ts_pkg::len_inc(len_reg);
                end
                else
                begin
                    do_flush = 1'b1;
                    do_fresh = 1'b1;
                end
            end
            ts_pkg::M_NUMBER:
            begin
                if (ts_pkg::is_digit(char_code))
                begin
                    len_next = ts_pkg::len_inc(len_reg);
                end
                else if (char_code == ts_pkg::CH_DOT)
                begin
                    mode_next = ts_pkg::M_NUMDOT;
                end
                else
                begin
                    do_flush = 1'b1;
                    do_fresh = 1'b1;
                end
            end
            ts_pkg::M_NUMDOT:
            begin
                if (ts_pkg::is_digit(char_code))
                begin
                    mode_next = ts_pkg::M_FRACTION;
                    len_next  = ts_pkg::len_inc(ts_pkg::len_inc(len_reg));
                end
                else
                begin
                    do_flush = 1'b1;
                    do_fresh = 1'b1;
                end
            end
            ts_pkg::M_FRACTION:
            begin
                if (ts_pkg::is_digit(char_code))
                begin
                    len_next = ts_pkg::len_inc(len_reg);
                end
                else
                begin
                    do_flush = 1'b1;
                    do_fresh = 1'b1;
                end
            end
            ts_pkg::M_STRING:
            begin
                len_next = ts_pkg::len_inc(len_reg);
                if (char_code == ts_pkg::CH_QUOTE)
                begin
                    direct_v   = 1'b1;
                    direct_tok = '{kind: ts_pkg::K_STRING, start: 16'(start_reg),
                                   length: len_next, last: 1'b0};
                    mode_next  = ts_pkg::M_IDLE;
                end
            end
            ts_pkg::M_COMMENT:
            begin
                if (char_code == ts_pkg::CH_NEWLINE)
                begin
                    mode_next = ts_pkg::M_IDLE;
                end
            end
            ts_pkg::M_SLASH:
            begin
                if (char_code == ts_pkg::CH_SLASH)
                begin
                    mode_next = ts_pkg::M_COMMENT;
                end
                else
                begin
                    do_flush = 1'b1;
                    do_fresh = 1'b1;
                end
            end
            ts_pkg::M_BANG, ts_pkg::M_EQUAL, ts_pkg::M_LESS, ts_pkg::M_GREATER:
            begin
                if (char_code == ts_pkg::CH_EQUAL)
                begin
                    direct_v   = 1'b1;
                    direct_tok = '{kind: ts_pkg::K_BANG_EQ, start: 16'(start_reg),
                                   length: 16'd2, last: 1'b0};
                    case (mode_reg)
                        ts_pkg::M_EQUAL:   direct_tok.kind = ts_pkg::K_EQ_EQ;
                        ts_pkg::M_LESS:    direct_tok.kind = ts_pkg::K_LESS_EQ;
                        ts_pkg::M_GREATER: direct_tok.kind = ts_pkg::K_GREATER_EQ;
                        default:           direct_tok.kind = ts_pkg::K_BANG_EQ;
                    endcase
                    mode_next = ts_pkg::M_IDLE;
                end
                else
                begin
                    do_flush = 1'b1;
                    do_fresh = 1'b1;
                end
            end
            default:
            begin
                do_fresh = 1'b1;
            end
        endcase

        // scan the byte afresh once the old token is closed
        if (do_fresh)
        begin
            mode_next = fresh.mode;
            if (fresh.open)
            begin
                start_next = pos_reg;
                len_next   = 16'd1;
                wcnt_next  = '0;
            end
            if (fresh.word)
            begin
                pfx_next[0] = char_code;
                wcnt_next   = WC_ONE;
            end
        end
    end

    // collect the tokens of this byte in order
    always_comb
    begin
        tok_n = 3'd0;
        for (int i = 0; i < 4; i++)
        begin
            tk[i] = '0;
        end
        if (do_flush && flush_cur.v0)
        begin
            tk[tok_n[1:0]] = flush_cur.t0;
            tok_n = tok_n + 3'd1;
        end
        if (do_flush && flush_cur.v1)
        begin
            tk[tok_n[1:0]] = flush_cur.t1;
            tok_n = tok_n + 3'd1;
        end
        if (do_fresh && fresh.emit)
        begin
            tk[tok_n[1:0]] = '{kind: fresh.kind, start: pos16, length: 16'd1, last: 1'b0};
            tok_n = tok_n + 3'd1;
        end
        if (direct_v)
        begin
            tk[tok_n[1:0]] = direct_tok;
            tok_n = tok_n + 3'd1;
        end
        // end of source closes what is pending and adds the end token
        if (end_of_source)
        begin
            if (flush_end.v0)
            begin
                tk[tok_n[1:0]] = flush_end.t0;
                tok_n = tok_n + 3'd1;
            end
            if (flush_end.v1)
            begin
                tk[tok_n[1:0]] = flush_end.t1;
                tok_n = tok_n + 3'd1;
            end
            tk[tok_n[1:0]] = '{kind: ts_pkg::K_END, start: 16'(pos_inc),
                               length: 16'd0, last: 1'b0};
            tok_n = tok_n + 3'd1;
        end
        // four due: the token of the final byte gives way
        if (tok_n == 3'd4)
        begin
            tk[2] = tk[3];
            tok_n = 3'd3;
        end
        if (tok_n != 3'd0)
        begin
            tk[2'(tok_n - 3'd1)].last = 1'b1;
        end
    end

    assign push_cnt = item_valid ? tok_n[1:0] : 2'd0;
    always_comb
    begin
        for (int i = 0; i < ts_pkg::TQ_BURST; i++)
        begin
            push_tok[i] = tk[i];
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= ts_pkg::M_IDLE;
            pos_reg   <= '0;
            start_reg <= '0;
            len_reg   <= '0;
            wcnt_reg  <= '0;
        end
        else if (item_valid)
        begin
            if (end_of_source)
            begin
                mode_reg  <= ts_pkg::M_IDLE;
                pos_reg   <= '0;
                start_reg <= '0;
                len_reg   <= '0;
                wcnt_reg  <= '0;
            end
            else
            begin
                mode_reg  <= mode_next;
                pos_reg   <= pos_inc;
                start_reg <= start_next;
                len_reg   <= len_next;
                wcnt_reg  <= wcnt_next;
            end
        end
    end

    // identifier prefix bytes
    always_ff @(posedge clk)
    begin
        if (item_valid)
        begin
            pfx_reg <= pfx_next;
        end
    end

endmodule

/* sv/ts_token_fifo.sv */
// ============================================================================
// ts_token_fifo: token queue
// Takes up to three tokens per cycle and hands them out one per cycle while pop
// is high; the head entry is the held output register of the result channel.
// ============================================================================
module ts_token_fifo (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [1:0]                   push_cnt,
    input  ts_pkg::ts_token_t            push_tok [ts_pkg::TQ_BURST],
    input  logic                         pop,
    output ts_pkg::ts_token_t            head,
    output logic [ts_pkg::TQ_CW-1:0]     count
);

    ts_pkg::ts_token_t             mem_reg [ts_pkg::TQ_DEPTH];
    logic [ts_pkg::TQ_AW-1:0]      wr_ptr_reg;
    logic [ts_pkg::TQ_AW-1:0]      rd_ptr_reg;
    logic [ts_pkg::TQ_CW-1:0]      count_reg;
    logic [ts_pkg::TQ_AW-1:0]      wr_addr [ts_pkg::TQ_BURST];

    // consecutive write slots
    always_comb
    begin
        for (int i = 0; i < ts_pkg::TQ_BURST; i++)
        begin
            wr_addr[i] = wr_ptr_reg + ts_pkg::TQ_AW'(i);
        end
    end

    // entry writes
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < ts_pkg::TQ_BURST; i++)
        begin
            if (2'(i) < push_cnt)
            begin
                mem_reg[wr_addr[i]] <= push_tok[i];
            end
        end
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + ts_pkg::TQ_AW'(push_cnt);
            rd_ptr_reg <= rd_ptr_reg + ts_pkg::TQ_AW'(pop);
            count_reg  <= count_reg + ts_pkg::TQ_CW'(push_cnt) - ts_pkg::TQ_CW'(pop);
        end
    end

    assign head  = mem_reg[rd_ptr_reg];
    assign count = count_reg;

endmodule

/* sv/token_scanner.sv */
// ============================================================================
// token_scanner: streaming lexical scanner
// Scans source bytes into tokens reported as kind, start offset and length.
// ============================================================================
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------------
//  src     | in        | src_valid, src_stall | char_code, end_of_source
//  tok     | out       | tok_valid, tok_stall | token_kind, token_start,
//          |           |                      | token_length, last_of_run
//
//  One byte per cycle while src_stall is low: a byte is registered on acceptance,
//  scanned in the next cycle and its zero to three tokens enter an eight-entry
//  token queue. Tokens leave one per cycle while tok_stall is low, so a byte that
//  yields several tokens hands them out one at a time; the queue's free room sets
//  src_stall. The first token of a byte passes the input register and a queue
//  entry before it shows on the result channel.
//  Reset returns the scanner to idle at offset zero with an empty queue.
//
module token_scanner #(
    parameter int POSITION_BITS = 16,
    parameter int KEYWORD_CHARS = 6
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        src_valid,
    output logic        src_stall,
    input  logic [7:0]  char_code,
    input  logic        end_of_source,
    output logic        tok_valid,
    input  logic        tok_stall,
    output logic [4:0]  token_kind,
    output logic [15:0] token_start,
    output logic [15:0] token_length,
    output logic        last_of_run
);

    localparam int NEED_W = ts_pkg::TQ_CW + 1;
    localparam logic [NEED_W-1:0] BURST_N = NEED_W'(ts_pkg::TQ_BURST);
    localparam logic [NEED_W-1:0] ROOM_LIMIT = NEED_W'(ts_pkg::TQ_DEPTH - ts_pkg::TQ_BURST);

    logic                        in_valid_reg;
    logic [7:0]                  char_reg;
    logic                        eos_reg;
    logic                        src_accept;
    logic [1:0]                  push_cnt;
    ts_pkg::ts_token_t           push_tok [ts_pkg::TQ_BURST];
    ts_pkg::ts_token_t           head;
    logic [ts_pkg::TQ_CW-1:0]    q_count;
    logic [NEED_W-1:0]           room_need;

    // stall while the queue could not take this byte and the one in flight
    assign room_need  = NEED_W'(q_count) + (in_valid_reg ? BURST_N : '0);
    assign src_stall  = room_need > ROOM_LIMIT;
    assign src_accept = src_valid && !src_stall;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= src_accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (src_accept)
        begin
            char_reg <= char_code;
            eos_reg  <= end_of_source;
        end
    end

    // scan logic
    ts_scan_core #(
        .POSITION_BITS (POSITION_BITS),
        .KEYWORD_CHARS (KEYWORD_CHARS)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (in_valid_reg),
        .char_code     (char_reg),
        .end_of_source (eos_reg),
        .push_cnt      (push_cnt),
        .push_tok      (push_tok)
    );

    // token queue
    ts_token_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push_cnt (push_cnt),
        .push_tok (push_tok),
        .pop      (tok_valid && !tok_stall),
        .head     (head),
        .count    (q_count)
    );

    // result channel
    assign tok_valid    = q_count != '0;
    assign token_kind   = head.kind;
    assign token_start  = head.start;
    assign token_length = head.length;
    assign last_of_run  = head.last;

endmodule
